// ----- hdl/three_axis_stepper_move_controller_core_defines.svh -----
// ----------------------------------------------------------------------------
// tasmc assertion macros
// shared concurrent assertion wrappers for the stepper controller
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_STEPPER_MOVE_CONTROLLER_CORE_DEFINES_SVH
`define THREE_AXIS_STEPPER_MOVE_CONTROLLER_CORE_DEFINES_SVH

// checked on every rising edge, off while reset is low
`define TASMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define TASMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tasmc_pkg.sv -----
// ----------------------------------------------------------------------------
// tasmc_pkg
// types, constants and the full-step coil table of the stepper controller
// ----------------------------------------------------------------------------
package tasmc_pkg;

    localparam int AXES = 3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    localparam logic [15:0] PERIOD_RESET = 16'd10;

    localparam logic [3:0] SEQ_TABLE [4] = '{4'b1001, 4'b1100, 4'b0110, 4'b0011};

    // shared command for all axis units for the beat in progress
    typedef struct packed {
        logic        fire;
        logic        tick;
        logic        move;
        logic        neg;
        logic [14:0] steps_m1;
        logic [31:0] stamp;
        logic [15:0] period;
    } t_axis_cmd;

    // next state view of one axis
    typedef struct packed {
        logic [3:0] coils;
        logic       busy;
        logic       stop;
    } t_axis_res;

    function automatic logic [3:0] seq_pattern(input logic [1:0] phase);
        return SEQ_TABLE[phase];
    endfunction

endpackage

// ----- hdl/tasmc_axis.sv -----
// ----------------------------------------------------------------------------
// tasmc_axis
// state and step logic of one stepper axis: move load, period check, stop
// ----------------------------------------------------------------------------
`include "three_axis_stepper_move_controller_core_defines.svh"

module tasmc_axis
    import tasmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_axis_cmd i_cmd,
    input  logic      i_sel,
    input  logic      i_endstop,
    output t_axis_res o_res
);

    logic [31:0] r_last,  n_last;
    logic [14:0] r_steps, n_steps;
    logic        r_fwd,   n_fwd;
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_coil,  n_coil;

    logic [31:0] w_elapsed;
    logic        w_due;
    logic        w_step;
    logic        w_dir;
    logic        w_stop;

    assign w_elapsed = i_cmd.stamp - r_last;
    assign w_due     = (r_steps != 15'd0) && (w_elapsed > {16'd0, i_cmd.period});

    always_comb begin
        n_last  = r_last;
        n_steps = r_steps;
        n_fwd   = r_fwd;
        n_phase = r_phase;
        n_coil  = r_coil;
        w_step  = 1'b0;
        w_dir   = r_fwd;
        w_stop  = 1'b0;
        if (i_cmd.fire) begin
            if (i_cmd.move && i_sel) begin
                n_last  = i_cmd.stamp;
                n_steps = i_cmd.steps_m1;
                n_fwd   = !i_cmd.neg;
                w_dir   = !i_cmd.neg;
                w_step  = !i_endstop;
            end else if (i_cmd.tick && w_due) begin
                n_last = i_cmd.stamp;
                if (i_endstop) begin
                    n_steps = 15'd0;
                    w_stop  = 1'b1;
                end else begin
                    n_steps = r_steps - 15'd1;
                    w_step  = 1'b1;
                end
            end
        end
        if (w_step) begin
            n_coil  = seq_pattern(r_phase);
            n_phase = w_dir ? r_phase + 2'd1 : r_phase - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_steps <= '0;
            r_fwd   <= 1'b0;
            r_phase <= '0;
            r_coil  <= '0;
        end else begin
            r_last  <= n_last;
            r_steps <= n_steps;
            r_fwd   <= n_fwd;
            r_phase <= n_phase;
            r_coil  <= n_coil;
        end
    end

    assign o_res.coils = n_coil;
    assign o_res.busy  = (n_steps != 15'd0);
    assign o_res.stop  = w_stop;

    `TASMC_ASSERT(a_stop_clears, i_clk, i_rst_n, w_stop |=> (r_steps == 15'd0), "stop left steps")
    `TASMC_ASSERT(a_coil_legal, i_clk, i_rst_n, (r_coil == 4'b0000) || (r_coil == 4'b1001) || (r_coil == 4'b1100) || (r_coil == 4'b0110) || (r_coil == 4'b0011), "bad coil pattern")
    `TASMC_ASSERT(a_stop_on_tick, i_clk, i_rst_n, w_stop |-> (i_cmd.tick && i_endstop), "stop outside tick")

endmodule

// ----- hdl/three_axis_stepper_move_controller_core.sv -----
// ----------------------------------------------------------------------------
// three_axis_stepper_move_controller_core
// full-step sequencer for three bipolar stepper axes with move and tick beats
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: axis, move_steps, endstops
//                                               tuser: command
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: coils x/y/z, stop, busy
//  cfg       in   i_cfg_wr_en                   i_cfg_wr_data: step_period_ms
//
//  one beat per cycle while the output is not stalled; a beat is captured in
//  the input register and its result lands in the output register when it
//  advances. the axis units work combinationally between the two registers.
//  reset is synchronous, clears the clock and all axis state, sets period 10.
//  a stalled output holds its beat while one more input beat is captured.
// ----------------------------------------------------------------------------
`include "three_axis_stepper_move_controller_core_defines.svh"

module three_axis_stepper_move_controller_core
    import tasmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // axis[1:0], move_steps[17:2], endstops[20:18], zero
    input  logic        s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // coils_x[3:0], coils_y[7:4], coils_z[11:8],
                                        // stop_status[14:12], busy_res[17:15], zero
);

    logic        r_period;
    logic [15:0] r_step_period;
    logic [31:0] r_time_now;

    logic               r_in_valid;
    logic               r_in_cmd;
    logic [1:0]         r_in_axis;
    logic signed [15:0] r_in_steps;
    logic [2:0]         r_in_stops;

    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic        w_adv;
    t_axis_cmd   w_cmd;
    t_axis_res   w_res [AXES];
    logic [3:0]  w_coils [3];
    logic [2:0]  w_stop;
    logic [2:0]  w_busy;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_step_period <= i_cfg_wr_data;
        end
    end

    // marks that a config write has been seen, used only by the config write assertion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_period <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_axis  <= s_axis_tdata[1:0];
            r_in_steps <= s_axis_tdata[17:2];
            r_in_stops <= s_axis_tdata[20:18];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_now <= '0;
        end else if (w_adv && r_in_cmd == CMD_TICK) begin
            r_time_now <= r_time_now + 32'd1;
        end
    end

    // |steps|-1 in 15 bits: negative counts come out as the inverted value
    always_comb begin
        w_cmd.fire     = w_adv;
        w_cmd.tick     = (r_in_cmd == CMD_TICK);
        w_cmd.move     = (r_in_cmd == CMD_MOVE) && (r_in_steps != 16'sd0);
        w_cmd.neg      = r_in_steps[15];
        w_cmd.steps_m1 = r_in_steps[15] ? ~r_in_steps[14:0] : r_in_steps[14:0] - 15'd1;
        w_cmd.stamp    = (r_in_cmd == CMD_TICK) ? r_time_now + 32'd1 : r_time_now;
        w_cmd.period   = r_step_period;
    end

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic w_hit;
        if (a < 3) begin : g_stop
            assign w_hit = r_in_stops[a];
        end else begin : g_nostop
            assign w_hit = 1'b0;
        end
        tasmc_axis u_axis (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_sel     (32'(r_in_axis) == a),
            .i_endstop (w_hit),
            .o_res     (w_res[a])
        );
    end

    for (genvar k = 0; k < 3; k++) begin : g_slot
        if (k < AXES) begin : g_used
            assign w_coils[k] = w_res[k].coils;
            assign w_stop[k]  = w_res[k].stop;
            assign w_busy[k]  = w_res[k].busy;
        end else begin : g_empty
            assign w_coils[k] = 4'd0;
            assign w_stop[k]  = 1'b0;
            assign w_busy[k]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {6'd0, w_busy, w_stop, w_coils[2], w_coils[1], w_coils[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `TASMC_ASSERT(a_out_from_adv, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(w_adv), "result without beat")
    `TASMC_ASSERT(a_tick_clock, i_clk, i_rst_n,
        (w_adv && r_in_cmd == CMD_TICK) |=> (r_time_now == $past(r_time_now) + 32'd1),
        "clock missed tick")
    `TASMC_ASSERT(a_move_no_stop, i_clk, i_rst_n,
        (w_adv && r_in_cmd == CMD_MOVE) |-> (w_stop == 3'd0), "stop on move beat")
    `TASMC_ASSERT_ALWAYS(a_cfg_mark, i_clk,
        (i_rst_n && i_cfg_wr_en) |=> r_period, "config write lost")

endmodule
